@@ hw/rtl/mss_pkg.sv @@
package mss_pkg;

  localparam int CELL_W     = 13;
  localparam int PRESS_W    = 16;
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 16;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int WINDOW_DEPTH_DEFAULT = 4;

  localparam logic [CELL_W-1:0] NOMINAL_CELL_MV = 13'd3800;

  // mission states
  localparam logic [MODE_W-1:0] M_START   = 4'd0;
  localparam logic [MODE_W-1:0] M_SURFACE = 4'd1;
  localparam logic [MODE_W-1:0] M_FLOAT   = 4'd2;
  localparam logic [MODE_W-1:0] M_DIVE    = 4'd3;
  localparam logic [MODE_W-1:0] M_BURN    = 4'd4;
  localparam logic [MODE_W-1:0] M_LPBURN  = 4'd5;
  localparam logic [MODE_W-1:0] M_RETR    = 4'd6;
  localparam logic [MODE_W-1:0] M_LPRETR  = 4'd7;
  localparam logic [MODE_W-1:0] M_ERROR   = 4'd8;

  // drive modes
  localparam logic [1:0] LED_BLINK     = 2'd0;
  localparam logic [1:0] LED_DIM       = 2'd1;
  localparam logic [1:0] LED_CUT       = 2'd2;
  localparam logic [1:0] GPS_OFF       = 2'd0;
  localparam logic [1:0] GPS_LOW_RATE  = 2'd1;
  localparam logic [1:0] GPS_HIGH_RATE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_ENABLED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_ENABLED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LOW_MV          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVE_PRESSURE_RAW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_PRESSURE_RAW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BURN_DEADLINE_S      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BURN_PERIOD_S        = 3'd6;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_a_mv;
    logic [CELL_W-1:0]  cell_b_mv;
    logic               battery_fault;
    logic [PRESS_W-1:0] pressure_raw;
    logic [TIME_W-1:0]  now_s;
  } tick_t;

  typedef struct packed {
    logic [MODE_W-1:0] mission_state;
    logic              state_changed;
    logic              low_voltage;
    logic              battery_error;
    logic              wire_heat;
    logic [1:0]        led_mode;
    logic [1:0]        gps_mode;
    logic              satellite_enabled;
  } result_t;

  typedef struct packed {
    logic                battery_enabled;
    logic                pressure_enabled;
    logic [CELL_W-1:0]   cell_low_mv;
    logic [PRESS_W-1:0]  dive_pressure_raw;
    logic [PRESS_W-1:0]  surface_pressure_raw;
    logic [TIME_W-1:0]   burn_deadline_s;
    logic [PERIOD_W-1:0] burn_period_s;
  } cfg_t;

endpackage

@@ hw/rtl/mss_tick_if.sv @@
interface mss_tick_if;
  import mss_pkg::*;

  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/mss_result_if.sv @@
interface mss_result_if;
  import mss_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/mss_cell_lane.sv @@
module mss_cell_lane #(
  parameter int WINDOW_DEPTH = mss_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [mss_pkg::CELL_W-1:0] cell_mv,
  input  logic [mss_pkg::CELL_W-1:0] low_mv,
  output logic                      low
);
  import mss_pkg::*;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = CELL_W + $clog2(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [SUM_W-1:0]  DEPTH_C   = SUM_W'(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0]  SUM_RESET = SUM_W'(int'(NOMINAL_CELL_MV) * WINDOW_DEPTH);
  localparam bit ONE_DEEP = (WINDOW_DEPTH == 1);

  logic [CELL_W-1:0]       mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] written;
  logic [SLOT_W-1:0]       slot;
  logic [SLOT_W-1:0]       slot_next;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]        sum_next;
  logic [SUM_W-1:0]        limit;
  logic [CELL_W-1:0]       mem_rd;
  logic [CELL_W-1:0]       last_mv;
  logic                    rd_hit;
  logic [CELL_W-1:0]       oldest_mv;

  // the sample that leaves the window next was fetched on the previous step
  assign oldest_mv = !rd_hit ? NOMINAL_CELL_MV : (ONE_DEEP ? last_mv : mem_rd);
  assign slot_next = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign sum_next  = sum + SUM_W'(cell_mv) - SUM_W'(oldest_mv);
  assign limit     = SUM_W'(low_mv) * DEPTH_C;
  assign low       = sum_next < limit;

  always_ff @(posedge clk) begin
    if (step) begin
      mem[slot] <= cell_mv;
      mem_rd    <= mem[slot_next];
      last_mv   <= cell_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      written <= '0;
      sum     <= SUM_RESET;
      rd_hit  <= 1'b0;
    end else if (step) begin
      written[slot] <= 1'b1;
      slot          <= slot_next;
      sum           <= sum_next;
      // unwritten entries count as the nominal reset sample
      rd_hit        <= written[slot_next] || (slot_next == slot);
    end
  end

endmodule

@@ hw/rtl/mss_mode_fsm.sv @@
module mss_mode_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mss_pkg::cfg_t    cfg,
  input  mss_pkg::tick_t   tick_in,
  input  logic             lane_low,
  output mss_pkg::result_t res
);
  import mss_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [MODE_W-1:0] mode_next;
  logic              burn_begun;
  logic [1:0]        fault_run;
  logic [1:0]        fault_run_next;
  logic              lowv;
  logic              berr;
  logic              time_up;
  logic              deep;
  logic              shallow;
  logic [TIME_W:0]   elapsed;
  logic              burn_done;
  logic              burning;

  // only "two or more" matters, so the run saturates at two
  assign fault_run_next = !tick_in.battery_fault ? 2'd0 :
                          (fault_run == 2'd2) ? fault_run : fault_run + 2'd1;

  assign lowv = cfg.battery_enabled && lane_low;
  assign berr = cfg.battery_enabled && (fault_run_next == 2'd2);

  assign time_up = tick_in.now_s >= cfg.burn_deadline_s;
  assign deep    = cfg.pressure_enabled && (tick_in.pressure_raw >= cfg.dive_pressure_raw);
  assign shallow = !cfg.pressure_enabled ||
                   (tick_in.pressure_raw < cfg.surface_pressure_raw);

  // signed distance past the deadline; while now_s is behind it the burn never completes
  assign elapsed   = {1'b0, tick_in.now_s} - {1'b0, cfg.burn_deadline_s};
  assign burn_done = burn_begun && !elapsed[TIME_W] &&
                     (elapsed[TIME_W-1:0] > TIME_W'(cfg.burn_period_s));

  always_comb begin
    case (mode)
      M_START:   mode_next = M_SURFACE;
      M_SURFACE: begin
        if (lowv || berr)  mode_next = M_LPBURN;
        else if (time_up)  mode_next = M_BURN;
        else if (deep)     mode_next = M_DIVE;
        else               mode_next = M_SURFACE;
      end
      M_FLOAT: begin
        if (lowv || berr || time_up) mode_next = M_LPBURN;
        else if (deep)               mode_next = M_DIVE;
        else                         mode_next = M_SURFACE;
      end
      M_DIVE: begin
        if (lowv || berr)  mode_next = M_LPBURN;
        else if (time_up)  mode_next = M_BURN;
        else if (shallow)  mode_next = M_SURFACE;
        else               mode_next = M_DIVE;
      end
      M_BURN: begin
        if (lowv || berr)    mode_next = M_LPBURN;
        else if (burn_done)  mode_next = M_RETR;
        else                 mode_next = M_BURN;
      end
      M_LPBURN:  mode_next = burn_done ? M_LPRETR : M_LPBURN;
      M_RETR:    mode_next = (lowv || berr) ? M_LPRETR : M_RETR;
      M_LPRETR:  mode_next = M_LPRETR;
      M_ERROR:   mode_next = M_SURFACE;
      default:   mode_next = M_ERROR;
    endcase
  end

  assign burning = (mode_next == M_BURN) || (mode_next == M_LPBURN);

  always_comb begin
    res.mission_state     = mode_next;
    res.state_changed     = mode_next != mode;
    res.low_voltage       = lowv;
    res.battery_error     = berr;
    res.wire_heat         = burning;
    if (burning) begin
      res.led_mode = LED_CUT;
    end else if (mode_next == M_DIVE || mode_next == M_RETR || mode_next == M_LPRETR) begin
      res.led_mode = LED_DIM;
    end else begin
      res.led_mode = LED_BLINK;
    end
    if (mode_next == M_DIVE) begin
      res.gps_mode = GPS_OFF;
    end else if (mode_next == M_LPRETR) begin
      res.gps_mode = GPS_LOW_RATE;
    end else begin
      res.gps_mode = GPS_HIGH_RATE;
    end
    res.satellite_enabled = !(mode_next == M_SURFACE || mode_next == M_DIVE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_START;
      burn_begun <= 1'b0;
      fault_run  <= 2'd0;
    end else if (step) begin
      mode <= mode_next;
      if (burning) begin
        burn_begun <= 1'b1;
      end
      // battery tracking freezes while the battery is disabled
      if (cfg.battery_enabled) begin
        fault_run <= fault_run_next;
      end
    end
  end

  a_no_float: assert property (@(posedge clk) disable iff (rst)
    mode != M_FLOAT)
    else $error("floating state entered");

  a_burn_marks: assert property (@(posedge clk) disable iff (rst)
    (mode == M_BURN || mode == M_LPBURN) |-> burn_begun)
    else $error("burn state without burn_begun");

  a_lpretr_final: assert property (@(posedge clk) disable iff (rst)
    step && mode == M_LPRETR |=> mode == M_LPRETR)
    else $error("left low-power retrieve");

  a_fault_clear: assert property (@(posedge clk) disable iff (rst)
    step && cfg.battery_enabled && !tick_in.battery_fault |=> fault_run == 2'd0)
    else $error("fault run not cleared by a good sample");

endmodule

@@ hw/rtl/mission_safety_sequencer.sv @@
// channel  dir  transaction / payload
// -------  ---  ------------------------------------------------------------
// tick     in   valid/ready; cell_a_mv, cell_b_mv, battery_fault,
//                pressure_raw, now_s
// result   out  valid/ready; mission_state, state_changed, low_voltage,
//                battery_error, wire_heat, led_mode, gps_mode, satellite_enabled
// cfg      in   cfg_we/cfg_addr/cfg_data, write only, taken every cycle
//
// One tick per cycle sustained while results are claimed; a tick's result appears
// in the output register in the cycle after acceptance. Both cell lanes and the
// mode step finish in the cycle a tick is accepted, so the next tick can
// follow at once. Reset is synchronous; window entries start from valid
// bits, so there is no clearing pass.
// tick.ready drops only while a result sits in the output register unclaimed.
module mission_safety_sequencer #(
  parameter int WINDOW_DEPTH = mss_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  mss_tick_if.sink                      tick,
  mss_result_if.source                  result,
  input  logic                          cfg_we,
  input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mss_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    lane_step;
  logic    low_a;
  logic    low_b;
  result_t res;

  assign tick.ready = !result.valid || result.ready;
  assign accept     = tick.valid && tick.ready;
  assign lane_step  = accept && cfg.battery_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_enabled      <= 1'b1;
      cfg.pressure_enabled     <= 1'b1;
      cfg.cell_low_mv          <= 13'd3300;
      cfg.dive_pressure_raw    <= 16'hFFFF;
      cfg.surface_pressure_raw <= 16'd0;
      cfg.burn_deadline_s      <= 32'd14400;
      cfg.burn_period_s        <= 16'd1200;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BATTERY_ENABLED:      cfg.battery_enabled      <= cfg_data[0];
        REG_PRESSURE_ENABLED:     cfg.pressure_enabled     <= cfg_data[0];
        REG_CELL_LOW_MV:          cfg.cell_low_mv          <= cfg_data[CELL_W-1:0];
        REG_DIVE_PRESSURE_RAW:    cfg.dive_pressure_raw    <= cfg_data[PRESS_W-1:0];
        REG_SURFACE_PRESSURE_RAW: cfg.surface_pressure_raw <= cfg_data[PRESS_W-1:0];
        REG_BURN_DEADLINE_S:      cfg.burn_deadline_s      <= cfg_data[TIME_W-1:0];
        REG_BURN_PERIOD_S:        cfg.burn_period_s        <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  mss_cell_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_a (
    .clk     (clk),
    .rst     (rst),
    .step    (lane_step),
    .cell_mv (tick.data.cell_a_mv),
    .low_mv  (cfg.cell_low_mv),
    .low     (low_a)
  );

  mss_cell_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_b (
    .clk     (clk),
    .rst     (rst),
    .step    (lane_step),
    .cell_mv (tick.data.cell_b_mv),
    .low_mv  (cfg.cell_low_mv),
    .low     (low_b)
  );

  mss_mode_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (accept),
    .cfg      (cfg),
    .tick_in  (tick.data),
    .lane_low (low_a || low_b),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.data <= res;
    end
  end

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted tick produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !tick.ready |-> (result.valid && !result.ready))
    else $error("input stalled without a pending result");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !accept) |=> !result.valid)
    else $error("result repeated after transaction");

endmodule
